/* rtl/core/wlmf_pkg.sv */
// shared types and constants for the windowed local minimum finder
package wlmf_pkg;

  localparam int MAX_BEFORE_DEF = 7;
  localparam int MAX_AFTER_DEF  = 7;
  localparam int MAX_LENGTH_DEF = 65536;

  localparam int SAMPLE_W  = 30;
  localparam int POS_W     = 17;
  localparam int CFG_W     = 3;
  localparam int CFG_IDX_W = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BEFORE = 1'b0,
    REG_AFTER  = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
  } in_item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
  } out_item_t;

endpackage

/* rtl/core/wlmf_window.sv */
// sample window shift register, newest sample at age 0
module wlmf_window #(
  parameter int DEPTH = 15
) (
  input  logic                          clk,
  input  logic                          load,
  input  logic                          shift,
  input  logic [wlmf_pkg::SAMPLE_W-1:0] sample,
  output logic [wlmf_pkg::SAMPLE_W-1:0] view [DEPTH]
);
  import wlmf_pkg::*;

  logic [SAMPLE_W-1:0] win_r [DEPTH];

  // view is the window as it stands once the current sample is in
  always_comb begin
    view[0] = shift ? sample : win_r[0];
    for (int i = 1; i < DEPTH; i++) begin
      view[i] = shift ? win_r[i-1] : win_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < DEPTH; i++) begin
        win_r[i] <= view[i];
      end
    end
  end

endmodule

/* rtl/core/wlmf_judge.sv */
// parallel minimum test of every candidate age, oldest qualifying candidate wins
module wlmf_judge #(
  parameter int MAX_BEFORE = wlmf_pkg::MAX_BEFORE_DEF,
  parameter int MAX_AFTER  = wlmf_pkg::MAX_AFTER_DEF,
  localparam int DEPTH = MAX_BEFORE + MAX_AFTER + 1,
  localparam int BW_W  = $clog2(MAX_BEFORE + 1),
  localparam int AGE_W = $clog2(MAX_AFTER + 1)
) (
  input  logic [wlmf_pkg::SAMPLE_W-1:0] view [DEPTH],
  input  logic [MAX_AFTER:0]            cand,
  input  logic [DEPTH-1:0]              avail,
  input  logic [BW_W-1:0]               bw,
  output logic                          hit,
  output logic [AGE_W-1:0]              age
);
  import wlmf_pkg::*;

  logic [MAX_AFTER:0] qual;

  always_comb begin
    for (int k = 0; k <= MAX_AFTER; k++) begin
      qual[k] = cand[k];
      for (int a = 0; a < DEPTH; a++) begin
        // newer samples: all of them up to the candidate
        if (a < k) begin
          if (view[a] <= view[k]) qual[k] = 1'b0;
        end else if (a > k && a <= k + int'(bw) && avail[a]) begin
          // older samples inside the before window and inside the sequence
          if (view[a] <= view[k]) qual[k] = 1'b0;
        end
      end
    end
  end

  // the oldest candidate is the lowest position
  always_comb begin
    hit = 1'b0;
    age = '0;
    for (int k = 0; k <= MAX_AFTER; k++) begin
      if (qual[k]) begin
        hit = 1'b1;
        age = AGE_W'(k);
      end
    end
  end

endmodule

/* rtl/core/windowed_local_minimum_finder.sv */
// Windowed local minimum finder: accepts one sample per cycle and reports, once per
// sequence, the first position whose sample is strictly below the before_window
// earlier and after_window later samples (windows clipped at the sequence ends),
// or found=0 on the last sample. An accepted sample is held in the input
// register, is judged there against the whole window by parallel comparators and
// leaves its result in the output register, so the sustained rate is one sample
// per cycle; a stalled output register stops intake.
module windowed_local_minimum_finder #(
  parameter int MAX_BEFORE = wlmf_pkg::MAX_BEFORE_DEF,
  parameter int MAX_AFTER  = wlmf_pkg::MAX_AFTER_DEF,
  parameter int MAX_LENGTH = wlmf_pkg::MAX_LENGTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  wlmf_pkg::in_item_t             in_data,
  output logic                           out_valid,
  input  logic                           out_stall,
  output wlmf_pkg::out_item_t            out_data,
  input  logic                           cfg_we,
  input  logic [wlmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wlmf_pkg::CFG_W-1:0]     cfg_wdata
);
  import wlmf_pkg::*;

  localparam int DEPTH = MAX_BEFORE + MAX_AFTER + 1;
  localparam int BW_W  = $clog2(MAX_BEFORE + 1);
  localparam int AGE_W = $clog2(MAX_AFTER + 1);
  localparam int CNT_W = $clog2(MAX_LENGTH + 1);

  logic [CFG_W-1:0] before_r, after_r;
  logic             s1_valid_r;
  in_item_t         s1_item_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             answered_r, answered_nxt;
  logic             out_valid_r;
  out_item_t        out_data_r;

  logic                adv, fire, room, judge_en, emit;
  logic [SAMPLE_W-1:0] view [DEPTH];
  logic [CNT_W-1:0]    newest, pos_full;
  logic [MAX_AFTER:0]  cand;
  logic [DEPTH-1:0]    avail;
  logic [BW_W-1:0]     bw_eff;
  int                  aw_i;
  logic                hit;
  logic [AGE_W-1:0]    age;
  out_item_t           result;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      before_r <= '0;
      after_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_BEFORE: before_r <= cfg_wdata;
        REG_AFTER:  after_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    bw_eff = (int'(before_r) > MAX_BEFORE) ? BW_W'(MAX_BEFORE) : BW_W'(before_r);
    aw_i   = (int'(after_r) > MAX_AFTER) ? MAX_AFTER : int'(after_r);
  end

  // handshake: the input register moves on whenever the output register can take a result
  assign adv      = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_item_r <= in_data;
    end
  end

  // room: sequence still below the length limit, so the sample is stored
  assign room     = count_r < CNT_W'(MAX_LENGTH);
  assign judge_en = fire && !answered_r;
  assign newest   = room ? count_r : count_r - CNT_W'(1);

  wlmf_window #(.DEPTH(DEPTH)) u_window (
    .clk    (clk),
    .load   (judge_en && room),
    .shift  (room),
    .sample (s1_item_r.sample),
    .view   (view)
  );

  always_comb begin
    for (int a = 0; a < DEPTH; a++) begin
      avail[a] = CNT_W'(a) <= newest;
    end
    for (int k = 0; k <= MAX_AFTER; k++) begin
      if (room && !s1_item_r.last) begin
        cand[k] = (k == aw_i) && avail[k];
      end else if (room) begin
        cand[k] = (k <= aw_i) && avail[k];
      end else begin
        // past the length limit only the last mark flushes what is still pending
        cand[k] = s1_item_r.last && (k < aw_i) && avail[k];
      end
    end
  end

  wlmf_judge #(.MAX_BEFORE(MAX_BEFORE), .MAX_AFTER(MAX_AFTER)) u_judge (
    .view  (view),
    .cand  (cand),
    .avail (avail),
    .bw    (bw_eff),
    .hit   (hit),
    .age   (age)
  );

  assign pos_full = newest - CNT_W'(age) + CNT_W'(1);
  assign emit     = judge_en && (hit || s1_item_r.last);

  always_comb begin
    result.found    = hit;
    result.position = hit ? POS_W'(pos_full) : '0;
  end

  // sequence bookkeeping
  always_comb begin
    count_nxt    = count_r;
    answered_nxt = answered_r;
    if (fire) begin
      if (s1_item_r.last) begin
        count_nxt    = '0;
        answered_nxt = 1'b0;
      end else if (!answered_r) begin
        if (room) count_nxt = count_r + CNT_W'(1);
        if (hit) answered_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= '0;
      answered_r <= 1'b0;
    end else begin
      count_r    <= count_nxt;
      answered_r <= answered_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* rtl/core/wlmf_checker.sv */
// port-level checks for the windowed local minimum finder, bound to the top level
module wlmf_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_stall,
  input logic                           out_valid,
  input logic                           out_stall,
  input wlmf_pkg::out_item_t            out_data
);
  import wlmf_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // intake only stops behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with the output free");

  // a miss carries no position
  a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.found |-> out_data.position == '0)
    else $error("miss reported with a position");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result present after reset");

endmodule

bind windowed_local_minimum_finder wlmf_checker u_wlmf_checker (.*);
